/* design/dual_quadrature_speed_estimator_assert.svh */
// Assertion macros shared by the estimator RTL.
`ifndef DUAL_QUADRATURE_SPEED_ESTIMATOR_ASSERT_SVH
`define DUAL_QUADRATURE_SPEED_ESTIMATOR_ASSERT_SVH

// A condition that must hold in the same cycle as its trigger.
`define DQSE_ASSERT_IMP(lbl, clk_s, rst_ns, trig, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (trig) |-> (cond)) \
		else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define DQSE_ASSERT_NXT(lbl, clk_s, rst_ns, trig, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* design/dqse_pkg.sv */
package dqse_pkg;

	// Gain register format and limits.
	localparam int GAIN_BITS  = 9;
	localparam int GAIN_SHIFT = 8;
	localparam logic [GAIN_BITS-1:0] GAIN_MAX   = 9'd256;
	localparam logic [GAIN_BITS-1:0] GAIN_RESET = 9'd77;

	// Width of each result field.
	localparam int OUT_BITS = 16;

	// Action codes carried in the input tuser.
	localparam logic ACT_POLL   = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	// Controls sent from the top level to each pulse counter.
	typedef struct packed {
		logic poll;    // count edges on this poll request
		logic first;   // first poll: only record the A level
		logic clear;   // update request: clear the count
	} cnt_ctl_t;

endpackage

/* design/dqse_counter.sv */
module dqse_counter import dqse_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cnt_ctl_t              ctl,
	input  logic                  pin_a,
	input  logic                  pin_b,
	output logic [COUNT_BITS-1:0] count
);

	logic                  a_prev_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  a_changed;

	assign a_changed = pin_a != a_prev_q;

	// Previous A level: loaded on the first poll and on every change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_prev_q <= 1'b0;
		end else if (ctl.poll && (ctl.first || a_changed)) begin
			a_prev_q <= pin_a;
		end
	end

	// Up when A moves to the level of B, down otherwise; wraps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (ctl.poll && !ctl.first && a_changed) begin
			if (pin_a == pin_b) begin
				count_q <= count_q + COUNT_BITS'(1);
			end else begin
				count_q <= count_q - COUNT_BITS'(1);
			end
		end
	end

	assign count = count_q;

endmodule

/* design/dqse_filter.sv */
module dqse_filter import dqse_pkg::*; #(
	parameter int COUNT_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  update,
	input  logic [GAIN_BITS-1:0]  gain,
	input  logic [COUNT_BITS-1:0] count,
	output logic [OUT_BITS-1:0]   speed,
	output logic [OUT_BITS-1:0]   taken
);

	localparam int W  = COUNT_BITS + FRAC_BITS + 2;
	localparam int DW = W + 1;
	localparam int PW = DW + GAIN_BITS + 1;
	localparam int EW = (W > OUT_BITS + FRAC_BITS) ? W : OUT_BITS + FRAC_BITS;
	localparam int TW = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

	logic signed [W-1:0]  filt_q;
	logic signed [W-1:0]  target;
	logic signed [DW-1:0] diff;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] step;
	logic signed [W-1:0]  filt_next;
	logic signed [W-1:0]  biased;
	logic signed [EW-1:0] biased_x;
	logic signed [TW-1:0] count_x;

	// Target is the count placed in the fixed-point format.
	assign target = $signed({{2{count[COUNT_BITS-1]}}, count, {FRAC_BITS{1'b0}}});
	assign diff   = $signed({target[W-1], target}) - $signed({filt_q[W-1], filt_q});

	// One gain multiply, floored by the arithmetic shift.
	assign prod      = diff * $signed({1'b0, gain});
	assign step      = prod >>> GAIN_SHIFT;
	assign filt_next = filt_q + step[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (update) begin
			filt_q <= filt_next;
		end
	end

	// Truncate toward zero: negative values get a bias before the floor.
	assign biased   = filt_next[W-1]
		? filt_next + $signed({{(W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}})
		: filt_next;
	assign biased_x = EW'(biased);
	assign speed    = biased_x[FRAC_BITS +: OUT_BITS];

	// Taken count, sign-extended or cut to the result width.
	assign count_x = TW'($signed(count));
	assign taken   = count_x[OUT_BITS-1:0];

endmodule

/* design/dual_quadrature_speed_estimator.sv */
// Path: a request is registered in the input register; an update's result then goes to the result
// register on m_tdata. Throughput: one request per cycle; an update waits in the stage only while
// an earlier result is held by m_tready low. Each update pays one 9 x (count+frac+3) bit multiply
// per encoder in the single processing stage, and the state is ready for the next request.
// Reset: arst_n clears counts, speeds and all valid flags at once; the gain returns to 77
// and the next poll only records the A levels.
module dual_quadrature_speed_estimator import dqse_pkg::*; #(
	parameter int COUNT_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,    // right_a, right_b, left_a, left_b, zero pad
	input  logic                 s_tuser,    // action
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [63:0]          m_tdata,    // right_speed, left_speed, right_taken, left_taken
	input  logic                 cfg_we,
	input  logic [GAIN_BITS-1:0] cfg_wdata
);

	`include "dual_quadrature_speed_estimator_assert.svh"

	logic                  s1_valid_s1;
	logic                  action_s1;
	logic [3:0]            pins_s1;
	logic                  first_q;
	logic [GAIN_BITS-1:0]  gain_q;
	logic [GAIN_BITS-1:0]  gain_eff;
	logic                  out_valid_q;
	logic [63:0]           out_data_q;
	logic                  s1_go;
	logic                  s1_poll;
	logic                  s1_update;
	cnt_ctl_t              ctl;
	logic [COUNT_BITS-1:0] right_count;
	logic [COUNT_BITS-1:0] left_count;
	logic [OUT_BITS-1:0]   right_speed;
	logic [OUT_BITS-1:0]   left_speed;
	logic [OUT_BITS-1:0]   right_taken;
	logic [OUT_BITS-1:0]   left_taken;

	// Gain register, clamped to unity for use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	assign gain_eff = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;

	// Stage control: only an update needs room in the result register.
	assign s1_go     = (action_s1 == ACT_POLL) || !out_valid_q || m_tready;
	assign s1_poll   = s1_valid_s1 && s1_go && (action_s1 == ACT_POLL);
	assign s1_update = s1_valid_s1 && s1_go && (action_s1 == ACT_UPDATE);
	assign s_tready  = !s1_valid_s1 || s1_go;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			s1_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			pins_s1   <= s_tdata[3:0];
		end
	end

	// First-poll flag: set by reset, cleared by the first poll.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (s1_poll) begin
			first_q <= 1'b0;
		end
	end

	assign ctl.poll  = s1_poll;
	assign ctl.first = first_q;
	assign ctl.clear = s1_update;

	dqse_counter #(.COUNT_BITS(COUNT_BITS)) u_right_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pin_a  (pins_s1[0]),
		.pin_b  (pins_s1[1]),
		.count  (right_count)
	);

	dqse_counter #(.COUNT_BITS(COUNT_BITS)) u_left_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pin_a  (pins_s1[2]),
		.pin_b  (pins_s1[3]),
		.count  (left_count)
	);

	dqse_filter #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_right_filt (
		.clk    (clk),
		.arst_n (arst_n),
		.update (s1_update),
		.gain   (gain_eff),
		.count  (right_count),
		.speed  (right_speed),
		.taken  (right_taken)
	);

	dqse_filter #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_left_filt (
		.clk    (clk),
		.arst_n (arst_n),
		.update (s1_update),
		.gain   (gain_eff),
		.count  (left_count),
		.speed  (left_speed),
		.taken  (left_taken)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_update) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_update) begin
			out_data_q <= {left_taken, right_taken, left_speed, right_speed};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Both counts are empty right after an update is processed.
	`DQSE_ASSERT_NXT(a_clear_after_update, clk, arst_n, s1_update, (right_count == '0) && (left_count == '0), "counts not cleared by update")
	// Once any poll has been processed, the first-poll flag is clear.
	`DQSE_ASSERT_NXT(a_first_cleared, clk, arst_n, s1_poll, !first_q, "first-poll flag still set after a poll")
	// A new result appears only when an update went through the stage.
	`DQSE_ASSERT_IMP(a_result_source, clk, arst_n, $rose(out_valid_q), $past(s1_update), "result without an update")

endmodule

/* sim/dual_quadrature_speed_estimator_tb.sv */
`timescale 1ns / 1ps

module dual_quadrature_speed_estimator_tb;
	import dqse_pkg::*;

	localparam int FRAC_BITS   = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 90;

	// One result as it travels on m_tdata; right_speed sits in the lowest bits.
	typedef struct packed {
		logic signed [15:0] left_taken;
		logic signed [15:0] right_taken;
		logic signed [15:0] left_speed;
		logic signed [15:0] right_speed;
	} speed_report_t;

	// A directed request; want is used only where typed is set.
	typedef struct packed {
		bit            typed;
		logic          act;
		logic          ra;
		logic          rb;
		logic          la;
		logic          lb;
		speed_report_t want;
	} pin_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;    // right_a, right_b, left_a, left_b, zero pad
	logic                 s_tuser;    // action
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [63:0]          m_tdata;    // right_speed, left_speed, right_taken, left_taken
	logic                 cfg_we;
	logic [GAIN_BITS-1:0] cfg_wdata;

	// Shadow of the estimator state.
	logic [GAIN_BITS-1:0] est_gain    = GAIN_RESET;
	logic                 est_r_prev  = 1'b0;
	logic                 est_l_prev  = 1'b0;
	logic                 est_first   = 1'b1;
	logic [15:0]          est_r_count = '0;
	logic [15:0]          est_l_count = '0;
	longint               est_r_filt  = 0;
	longint               est_l_filt  = 0;

	speed_report_t speed_queue [$];
	int            fail_count  = 0;
	int            cycle_count = 0;

	// Receiver hold-off and idle control.
	int  hold_seq  = 0;
	int  hold_seen = 0;
	int  ready_gap = 0;
	bit  recv_idle = 1'b0;
	bit  send_idle = 1'b0;

	// Gray position and preferred direction of each simulated wheel.
	logic [1:0] wheel_r = 2'd0;
	logic [1:0] wheel_l = 2'd0;
	logic [1:0] dir_r   = 2'd1;
	logic [1:0] dir_l   = 2'd3;

	string result_field [4] = '{"right_speed", "left_speed", "right_taken", "left_taken"};

	logic [GAIN_BITS-1:0] phase_gain [PHASES] =
		'{9'd0, 9'd511, GAIN_MAX, 9'd1, 9'd257, 9'd128, 9'd0, GAIN_RESET};

	// Directed requests: the first update comes before any poll, the first poll only
	// records A, then every edge case on both encoders, a B change without an A
	// change, and a negative average that must truncate toward zero.
	pin_row_t directed_rows [14] = '{
		'{1'b1, ACT_UPDATE, 1'b0, 1'b0, 1'b0, 1'b0, '0},
		'{1'b0, ACT_POLL,   1'b1, 1'b0, 1'b0, 1'b1, '0},
		'{1'b0, ACT_POLL,   1'b0, 1'b0, 1'b1, 1'b1, '0},
		'{1'b0, ACT_POLL,   1'b1, 1'b1, 1'b0, 1'b1, '0},
		'{1'b0, ACT_POLL,   1'b1, 1'b0, 1'b0, 1'b0, '0},
		'{1'b0, ACT_POLL,   1'b0, 1'b1, 1'b1, 1'b0, '0},
		'{1'b1, ACT_UPDATE, 1'b0, 1'b0, 1'b0, 1'b0, '{-16'sd1, 16'sd1, 16'sd0, 16'sd0}},
		'{1'b1, ACT_UPDATE, 1'b1, 1'b1, 1'b1, 1'b1, '0},
		'{1'b0, ACT_POLL,   1'b1, 1'b1, 1'b0, 1'b0, '0},
		'{1'b0, ACT_POLL,   1'b1, 1'b0, 1'b0, 1'b1, '0},
		'{1'b0, ACT_POLL,   1'b0, 1'b0, 1'b1, 1'b1, '0},
		'{1'b0, ACT_POLL,   1'b0, 1'b0, 1'b1, 1'b1, '0},
		'{1'b0, ACT_POLL,   1'b1, 1'b0, 1'b0, 1'b1, '0},
		'{1'b0, ACT_UPDATE, 1'b0, 1'b0, 1'b0, 1'b0, '0}
	};

	dual_quadrature_speed_estimator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Count change for one encoder: nothing without an A change, up when A matches B.
	function automatic logic [15:0] pulse_step(logic prev, logic a, logic b);
		if (a == prev)
			return 16'd0;
		return (a == b) ? 16'd1 : 16'hFFFF;
	endfunction

	// Exponential average in Q.8 with the gain clamped to full scale.
	function automatic longint ema_step(longint s, logic [15:0] cnt);
		longint g;
		longint target;
		g = (est_gain > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(est_gain);
		target = longint'($signed(cnt)) * (longint'(1) << FRAC_BITS);
		return s + ((g * (target - s)) >>> GAIN_SHIFT);
	endfunction

	// Integer speed, truncated toward zero.
	function automatic logic [15:0] speed_trunc(longint s);
		longint v;
		v = s / (longint'(1) << FRAC_BITS);
		return v[15:0];
	endfunction

	// Next wheel move: mostly the preferred direction, sometimes a pause or a reversal.
	function automatic logic [1:0] wheel_step(logic [1:0] dir);
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 14)
			return dir;
		if (roll < 17)
			return 2'd0;
		return 2'd0 - dir;
	endfunction

	// Advance the shadow state by one request; pins are {left_b, left_a, right_b, right_a}.
	task automatic advance_estimator(input logic act, input logic [3:0] pins,
			output bit has, output speed_report_t rpt);
		logic [15:0] r_taken;
		logic [15:0] l_taken;
		has = 1'b0;
		rpt = '0;
		if (act == ACT_POLL) begin
			if (!est_first) begin
				est_r_count += pulse_step(est_r_prev, pins[0], pins[1]);
				est_l_count += pulse_step(est_l_prev, pins[2], pins[3]);
			end
			est_first  = 1'b0;
			est_r_prev = pins[0];
			est_l_prev = pins[2];
		end else begin
			r_taken     = est_r_count;
			l_taken     = est_l_count;
			est_r_count = '0;
			est_l_count = '0;
			est_r_filt  = ema_step(est_r_filt, r_taken);
			est_l_filt  = ema_step(est_l_filt, l_taken);
			rpt.right_speed = speed_trunc(est_r_filt);
			rpt.left_speed  = speed_trunc(est_l_filt);
			rpt.right_taken = r_taken;
			rpt.left_taken  = l_taken;
			has = 1'b1;
		end
	endtask

	// Offer one request, wait for it to be taken, and record what it should produce.
	task automatic send_request(input logic act, input logic [3:0] pins, input bit typed,
			input speed_report_t typed_rpt);
		bit            has;
		speed_report_t rpt;
		if (send_idle && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {4'b0000, pins};
		do @(posedge clk); while (!s_tready);
		advance_estimator(act, pins, has, rpt);
		if (has)
			speed_queue.push_back(typed ? typed_rpt : rpt);
	endtask

	// Random request: mostly clean quadrature motion, some pin noise, some updates.
	task automatic send_random_request();
		logic [3:0] pins;
		pins = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 11) == 0) begin
			send_request(ACT_UPDATE, pins, 1'b0, '0);
		end else begin
			if ($urandom_range(0, 6) != 0) begin
				wheel_r = wheel_r + wheel_step(dir_r);
				wheel_l = wheel_l + wheel_step(dir_l);
				pins = {wheel_l[1], wheel_l[0] ^ wheel_l[1], wheel_r[1], wheel_r[0] ^ wheel_r[1]};
			end
			send_request(ACT_POLL, pins, 1'b0, '0);
		end
	endtask

	// Let every expected result come out, then wait for polls still in flight.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (speed_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_gain(input logic [GAIN_BITS-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		est_gain = value;
	endtask

	// A clean run: right counts up and left counts down n times, then an update.
	task automatic run_pulses(input int n);
		logic ra;
		logic la;
		for (int i = 0; i < n; i++) begin
			ra = ~est_r_prev;
			la = ~est_l_prev;
			send_request(ACT_POLL, {~la, la, ra, ra}, 1'b0, '0);
		end
		send_request(ACT_UPDATE, 4'b0000, 1'b0, '0);
	endtask

	// Check each result against the oldest expectation, then choose the next ready.
	always @(posedge clk) begin
		speed_report_t want;
		logic [63:0]   want_bits;
		if (m_tvalid && m_tready) begin
			if (speed_queue.size() == 0) begin
				$display("%0t: result with none expected: %h", $realtime, m_tdata);
				fail_count++;
			end else begin
				want      = speed_queue.pop_front();
				want_bits = want;
				for (int f = 0; f < 4; f++) begin
					if (m_tdata[16*f +: 16] !== want_bits[16*f +: 16]) begin
						$display("%0t: %s expected %0d, got %0d", $realtime, result_field[f],
							$signed(want_bits[16*f +: 16]), $signed(m_tdata[16*f +: 16]));
						fail_count++;
					end
				end
			end
		end
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			ready_gap <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (ready_gap != 0) begin
			ready_gap <= ready_gap - 1;
			m_tready  <= 1'b0;
		end else if (recv_idle && $urandom_range(0, 7) == 0) begin
			ready_gap <= $urandom_range(0, 18);
			m_tready  <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		pin_row_t row;
		s_tvalid  <= 1'b0;
		s_tuser   <= ACT_POLL;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset gain.
		for (int i = 0; i < 14; i++) begin
			row = directed_rows[i];
			send_request(row.act, {row.lb, row.la, row.rb, row.ra}, row.typed, row.want);
		end

		// Random phases, one gain setting each; phase 3 and the last two run without idling.
		phase_gain[6] = 9'($urandom_range(0, 511));
		for (int p = 0; p < PHASES; p++) begin
			write_gain(phase_gain[p]);
			send_idle = (p < 6) && (p != 3);
			recv_idle <= (p < 6) && (p != 3);
			dir_r = $urandom_range(0, 1) ? 2'd1 : 2'd3;
			dir_l = $urandom_range(0, 1) ? 2'd1 : 2'd3;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				send_random_request();
				// Once, hold the receiver off while updates keep coming.
				if (p == 2 && k == PHASE_ITEMS / 2) begin
					hold_seq <= hold_seq + 1;
					repeat (40) send_request(ACT_UPDATE, 4'b0000, 1'b0, '0);
				end
			end
		end

		// Clean runs at full gain, where the speed follows the count at once.
		write_gain(GAIN_MAX);
		run_pulses(20);
		run_pulses(21);
		run_pulses(22);

		drain();
		for (int i = 0; i < speed_queue.size(); i++)
			fail_count++;
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
